@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

@@ hw/rtl/rmt_pkg.sv @@
package rmt_pkg;

    localparam int CW   = 16;   // input component width
    localparam int DW   = 34;   // dot product width
    localparam int PW   = 68;   // product of two dot products
    localparam int NW   = 67;   // determinant and numerators
    localparam int SW   = 88;   // coordinate numerator, signed
    localparam int MW   = 87;   // its magnitude
    localparam int RW   = 100;  // divider remainder and shifted divisor
    localparam int QW   = 33;   // quotient bits built by the cell chain
    localparam int LIMW = 24;   // limit register width
    localparam int OW   = 32;   // output coordinate width
    localparam int LAT  = 42;   // transfer to strobe, in cycles

    localparam logic [LIMW-1:0] LIMIT_RST = 24'd1678;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_BEHIND   = 2'd2;

    localparam logic [OW-1:0] PT_MAX = 32'h7FFF_FFFF;
    localparam logic [OW-1:0] PT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                   vld;
        logic [1:0]             status;
        logic [2:0]             sat;
        logic [2:0]             neg;
        logic [2:0][RW-1:0]     rem;
        logic [2:0][QW-1:0]     quo;
        logic [RW-1:0]          dsh;
    } t_cell;

endpackage

@@ hw/rtl/rmt_front.sv @@
module rmt_front (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [2:0][rmt_pkg::CW-1:0]               i_a,
    input  logic [2:0][rmt_pkg::CW-1:0]               i_b,
    input  logic [2:0][rmt_pkg::CW-1:0]               i_t,
    input  logic [rmt_pkg::LIMW-1:0]                  i_limit,
    output rmt_pkg::t_cell                            o_cell
);

    // stage 1: component products
    logic                               r1_v;
    logic signed [31:0]                 r1_pa [3];
    logic signed [31:0]                 r1_pb [3];
    logic signed [31:0]                 r1_pab [3];
    logic signed [31:0]                 r1_pta [3];
    logic signed [31:0]                 r1_ptb [3];
    logic [2:0][rmt_pkg::CW-1:0]        r1_a, r1_b, r1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start;
            for (int k = 0; k < 3; k++) begin
                r1_pa[k]  <= $signed(i_a[k]) * $signed(i_a[k]);
                r1_pb[k]  <= $signed(i_b[k]) * $signed(i_b[k]);
                r1_pab[k] <= $signed(i_a[k]) * $signed(i_b[k]);
                r1_pta[k] <= $signed(i_t[k]) * $signed(i_a[k]);
                r1_ptb[k] <= $signed(i_t[k]) * $signed(i_b[k]);
            end
            r1_a <= i_a;
            r1_b <= i_b;
            r1_t <= i_t;
        end
    end

    // stage 2: dot products
    logic                               r2_v;
    logic signed [rmt_pkg::DW-1:0]      r2_aa, r2_bb, r2_ab, r2_ta, r2_tb;
    logic [2:0][rmt_pkg::CW-1:0]        r2_a, r2_b, r2_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v  <= r1_v;
            r2_aa <= rmt_pkg::DW'(r1_pa[0]) + rmt_pkg::DW'(r1_pa[1]) + rmt_pkg::DW'(r1_pa[2]);
            r2_bb <= rmt_pkg::DW'(r1_pb[0]) + rmt_pkg::DW'(r1_pb[1]) + rmt_pkg::DW'(r1_pb[2]);
            r2_ab <= rmt_pkg::DW'(r1_pab[0]) + rmt_pkg::DW'(r1_pab[1])
                   + rmt_pkg::DW'(r1_pab[2]);
            r2_ta <= rmt_pkg::DW'(r1_pta[0]) + rmt_pkg::DW'(r1_pta[1])
                   + rmt_pkg::DW'(r1_pta[2]);
            r2_tb <= rmt_pkg::DW'(r1_ptb[0]) + rmt_pkg::DW'(r1_ptb[1])
                   + rmt_pkg::DW'(r1_ptb[2]);
            r2_a <= r1_a;
            r2_b <= r1_b;
            r2_t <= r1_t;
        end
    end

    // stage 3: products of dot products
    logic                               r3_v;
    logic signed [rmt_pkg::PW-1:0]      r3_aabb, r3_abab, r3_tabb, r3_tbab, r3_taab, r3_tbaa;
    logic [2:0][rmt_pkg::CW-1:0]        r3_a, r3_b, r3_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v    <= r2_v;
            r3_aabb <= rmt_pkg::PW'(r2_aa) * rmt_pkg::PW'(r2_bb);
            r3_abab <= rmt_pkg::PW'(r2_ab) * rmt_pkg::PW'(r2_ab);
            r3_tabb <= rmt_pkg::PW'(r2_ta) * rmt_pkg::PW'(r2_bb);
            r3_tbab <= rmt_pkg::PW'(r2_tb) * rmt_pkg::PW'(r2_ab);
            r3_taab <= rmt_pkg::PW'(r2_ta) * rmt_pkg::PW'(r2_ab);
            r3_tbaa <= rmt_pkg::PW'(r2_tb) * rmt_pkg::PW'(r2_aa);
            r3_a <= r2_a;
            r3_b <= r2_b;
            r3_t <= r2_t;
        end
    end

    // stage 4: determinant and numerators
    logic                               r4_v;
    logic signed [rmt_pkg::NW-1:0]      r4_d, r4_n1, r4_n2;
    logic [2:0][rmt_pkg::CW-1:0]        r4_a, r4_b, r4_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v  <= r3_v;
            r4_d  <= rmt_pkg::NW'(r3_aabb - r3_abab);
            r4_n1 <= rmt_pkg::NW'(r3_tabb - r3_tbab);
            r4_n2 <= rmt_pkg::NW'(r3_taab - r3_tbaa);
            r4_a <= r3_a;
            r4_b <= r3_b;
            r4_t <= r3_t;
        end
    end

    // stage 5: classify, scale directions by the numerators
    logic                               r5_v;
    logic [1:0]                         r5_status;
    logic signed [rmt_pkg::NW-1:0]      r5_d;
    logic signed [rmt_pkg::SW-1:0]      r5_an [3];
    logic signed [rmt_pkg::SW-1:0]      r5_tn [3];
    logic signed [rmt_pkg::SW-1:0]      r5_bn [3];
    logic [rmt_pkg::NW-1:0]             w_lim;
    logic                               w_par;

    assign w_lim = rmt_pkg::NW'({i_limit, 24'd0});
    assign w_par = (r4_d == '0) || ($unsigned(r4_d) < w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
            if (w_par) begin
                r5_status <= rmt_pkg::ST_PARALLEL;
            end else if (r4_n1[rmt_pkg::NW-1] || r4_n2[rmt_pkg::NW-1]) begin
                r5_status <= rmt_pkg::ST_BEHIND;
            end else begin
                r5_status <= rmt_pkg::ST_OK;
            end
            r5_d <= r4_d;
            for (int k = 0; k < 3; k++) begin
                r5_an[k] <= rmt_pkg::SW'($signed(r4_a[k])) * rmt_pkg::SW'(r4_n1);
                r5_tn[k] <= rmt_pkg::SW'($signed(r4_t[k])) * rmt_pkg::SW'(r4_d);
                r5_bn[k] <= rmt_pkg::SW'($signed(r4_b[k])) * rmt_pkg::SW'(r4_n2);
            end
        end
    end

    // stage 6: coordinate numerators with rounding offset
    logic                               r6_v;
    logic [1:0]                         r6_status;
    logic signed [rmt_pkg::NW-1:0]      r6_d;
    logic signed [rmt_pkg::SW-1:0]      r6_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v      <= r5_v;
            r6_status <= r5_status;
            r6_d      <= r5_d;
            for (int k = 0; k < 3; k++) begin
                r6_s[k] <= r5_an[k] + r5_tn[k] + r5_bn[k] + rmt_pkg::SW'(r5_d);
            end
        end
    end

    // stage 7: sign and magnitude
    logic                               r7_v;
    logic [1:0]                         r7_status;
    logic [rmt_pkg::NW-1:0]             r7_den;
    logic [2:0]                         r7_neg;
    logic [rmt_pkg::MW-1:0]             r7_mag [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v      <= r6_v;
            r7_status <= r6_status;
            r7_den    <= {r6_d[rmt_pkg::NW-2:0], 1'b0};
            for (int k = 0; k < 3; k++) begin
                r7_neg[k] <= r6_s[k][rmt_pkg::SW-1];
                r7_mag[k] <= rmt_pkg::MW'(r6_s[k][rmt_pkg::SW-1] ? -r6_s[k] : r6_s[k]);
            end
        end
    end

    // stage 8: overflow check and divider seed
    rmt_pkg::t_cell r8_cell;
    logic [rmt_pkg::RW-1:0] w_den;

    assign w_den = rmt_pkg::RW'(r7_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_cell.vld <= 1'b0;
        end else begin
            r8_cell.vld    <= r7_v;
            r8_cell.status <= r7_status;
            r8_cell.neg    <= r7_neg;
            r8_cell.dsh    <= w_den << (rmt_pkg::QW - 1);
            for (int k = 0; k < 3; k++) begin
                r8_cell.sat[k] <= rmt_pkg::RW'(r7_mag[k]) >= (w_den << rmt_pkg::QW);
                r8_cell.rem[k] <= rmt_pkg::RW'(r7_mag[k]);
                r8_cell.quo[k] <= '0;
            end
        end
    end

    assign o_cell = r8_cell;

endmodule

@@ hw/rtl/rmt_div_cell.sv @@
module rmt_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rmt_pkg::t_cell  i_cell,
    output rmt_pkg::t_cell  o_cell
);

    rmt_pkg::t_cell r_cell;
    rmt_pkg::t_cell n_cell;

    // one restoring step per lane, then halve the divisor for the next cell
    always_comb begin
        n_cell     = i_cell;
        n_cell.dsh = i_cell.dsh >> 1;
        for (int k = 0; k < 3; k++) begin
            if (i_cell.rem[k] >= i_cell.dsh) begin
                n_cell.rem[k] = i_cell.rem[k] - i_cell.dsh;
                n_cell.quo[k] = {i_cell.quo[k][rmt_pkg::QW-2:0], 1'b1};
            end else begin
                n_cell.quo[k] = {i_cell.quo[k][rmt_pkg::QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

@@ hw/rtl/ray_midpoint_triangulation.sv @@
// Pipeline: a start transfer reaches its result strobe through 8 front-end stages,
// 33 divider cells and 1 output register.
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (i_rst_n low, synchronous) drops every item in flight and sets the limit to 1678.
`include "assert_macros.svh"

module ray_midpoint_triangulation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [15:0]            i_ray_a_x,
    input  logic signed [15:0]            i_ray_a_y,
    input  logic signed [15:0]            i_ray_a_z,
    input  logic signed [15:0]            i_ray_b_x,
    input  logic signed [15:0]            i_ray_b_y,
    input  logic signed [15:0]            i_ray_b_z,
    input  logic signed [15:0]            i_base_x,
    input  logic signed [15:0]            i_base_y,
    input  logic signed [15:0]            i_base_z,
    // result channel
    output logic                          o_valid,
    output logic signed [31:0]            o_point_x,
    output logic signed [31:0]            o_point_y,
    output logic signed [31:0]            o_point_z,
    output logic [1:0]                    o_status,
    // limit register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmt_pkg::LIMW-1:0]      i_cfg_data
);

    // The pipeline never backs up, so input is always taken.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Degenerate limit: written by a transfer on the config channel.
    logic [rmt_pkg::LIMW-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rmt_pkg::LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // Front end: dot products, determinant, numerators, classification,
    // coordinate numerators and divider seed.
    logic [2:0][rmt_pkg::CW-1:0] w_a, w_b, w_t;

    assign w_a = {i_ray_a_z, i_ray_a_y, i_ray_a_x};
    assign w_b = {i_ray_b_z, i_ray_b_y, i_ray_b_x};
    assign w_t = {i_base_z, i_base_y, i_base_x};

    rmt_pkg::t_cell w_chain [rmt_pkg::QW+1];

    rmt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_t     (w_t),
        .i_limit (r_limit),
        .o_cell  (w_chain[0])
    );

    // Divider: a row of identical cells, each settles one quotient bit
    // for all three coordinates and hands its word to the next cell.
    for (genvar g = 0; g < rmt_pkg::QW; g++) begin : g_cell
        rmt_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // Output: floor rounding for negative values, saturation, zero on failure.
    rmt_pkg::t_cell             w_last;
    logic [2:0][rmt_pkg::OW-1:0] n_point;
    logic [rmt_pkg::QW:0]        w_mag [3];

    assign w_last = w_chain[rmt_pkg::QW];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = {1'b0, w_last.quo[k]} + (rmt_pkg::QW + 1)'(w_last.rem[k] != '0);
            if (w_last.status != rmt_pkg::ST_OK) begin
                n_point[k] = '0;
            end else if (w_last.sat[k]) begin
                n_point[k] = w_last.neg[k] ? rmt_pkg::PT_MIN : rmt_pkg::PT_MAX;
            end else if (!w_last.neg[k]) begin
                n_point[k] = (w_last.quo[k][rmt_pkg::QW-1] || w_last.quo[k][rmt_pkg::QW-2])
                           ? rmt_pkg::PT_MAX : w_last.quo[k][rmt_pkg::OW-1:0];
            end else begin
                n_point[k] = (w_mag[k] > (rmt_pkg::QW + 1)'(rmt_pkg::PT_MIN))
                           ? rmt_pkg::PT_MIN : rmt_pkg::OW'(-w_mag[k]);
            end
        end
    end

    logic                        r_valid;
    logic [2:0][rmt_pkg::OW-1:0] r_point;
    logic [1:0]                  r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid  <= w_last.vld;
            r_point  <= n_point;
            r_status <= w_last.status;
        end
    end

    assign o_valid   = r_valid;
    assign o_point_x = r_point[0];
    assign o_point_y = r_point[1];
    assign o_point_z = r_point[2];
    assign o_status  = r_status;

    // The last cell's divisor is half the full divisor, so the final
    // remainder must stay below twice that value.
    `ASSERT_CLK(a_latency, (start && !busy) |-> ##(rmt_pkg::LAT) o_valid, "result missing")
    `ASSERT_CLK(a_fail_zero,
        (o_valid && o_status != rmt_pkg::ST_OK)
            |-> (o_point_x == 0 && o_point_y == 0 && o_point_z == 0), "failed point not zero")
    `ASSERT_CLK(a_status_code,
        o_valid |-> (o_status == rmt_pkg::ST_OK || o_status == rmt_pkg::ST_PARALLEL
            || o_status == rmt_pkg::ST_BEHIND), "bad status code")
    `ASSERT_NEVER(a_quo_fit,
        w_last.vld && w_last.status == rmt_pkg::ST_OK && !w_last.sat[0]
            && (w_last.rem[0] >= (w_last.dsh << 1)), "divider remainder too large")

endmodule
